FILE: hdl/grid_astar_path_search_unit_defines.svh
// assertion macros used by the grid path search top level
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define GAPS_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication check failed");
`define GAPS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next cycle check failed");
`else
`define GAPS_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define GAPS_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

FILE: hdl/gaps_pkg.sv
// shared types, codes and helpers of the grid path search unit
`default_nettype none
package gaps_pkg;
	localparam int GRID_COLS_DEF = 64;
	localparam int GRID_ROWS_DEF = 64;
	localparam logic [7:0] STRAIGHT_RST = 8'd10;
	localparam logic [7:0] DIAG_RST = 8'd14;
	localparam logic [15:0] G_MAX = 16'hFFFF;
	localparam logic [16:0] F_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		OP_BLOCK  = 2'd0,
		OP_FREE   = 2'd1,
		OP_SEARCH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOPATH = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [0:0] {
		CFG_STRAIGHT = 1'b0,
		CFG_DIAG     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [5:0]  goal_col;
		logic [5:0]  goal_row;
		logic [11:0] entry_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [12:0] path_length;
		logic [5:0]  tile_col;
		logic [5:0]  tile_row;
		logic [15:0] path_cost;
	} out_word_t;

	typedef struct packed {
		logic go;
		logic idle;
	} ctl_hs_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_SRD,
		S_SWR,
		S_NA,
		S_NB,
		S_NC,
		S_NEV,
		S_EXPEND,
		S_SCAN,
		S_PICK,
		S_PRD,
		S_PWR,
		S_RWAIT,
		S_DONE
	} state_t;

	// neighbor order: row above left to right, same row, row below
	function automatic logic signed [1:0] nbr_dx(input logic [2:0] k);
		logic signed [1:0] d;
		unique case (k)
			3'd0, 3'd3, 3'd5: d = -2'sd1;
			3'd1, 3'd6:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] nbr_dy(input logic [2:0] k);
		logic signed [1:0] d;
		unique case (k)
			3'd0, 3'd1, 3'd2: d = -2'sd1;
			3'd3, 3'd4:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/gaps_req_if.sv
// request channel of the grid path search unit
`default_nettype none
interface gaps_req_if;
	logic valid;
	logic ready;
	gaps_pkg::in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/gaps_rsp_if.sv
// response channel of the grid path search unit
`default_nettype none
interface gaps_rsp_if;
	logic valid;
	logic ready;
	gaps_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/gaps_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module gaps_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/gaps_ctrl.sv
// search sequencer: tile map, node table and open list / path list walks
`default_nettype none
module gaps_ctrl #(
	parameter int GRID_COLS = gaps_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gaps_pkg::GRID_ROWS_DEF,
	localparam int CW = $clog2(GRID_COLS),
	localparam int RW = $clog2(GRID_ROWS),
	localparam int AW = CW + RW,
	localparam int NW = AW + 37
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gaps_pkg::ctl_hs_t   hs_in,
	output gaps_pkg::ctl_hs_t        hs_out,
	input  wire gaps_pkg::in_word_t  cmd,
	input  wire logic [7:0]          sc,
	input  wire logic [7:0]          dc,
	output logic                     res_valid,
	output gaps_pkg::out_word_t      res,
	output logic                     node_we,
	output logic [AW-1:0]            node_waddr,
	output logic [NW-1:0]            node_wdata,
	output logic [AW-1:0]            node_raddr,
	input  wire logic [NW-1:0]       node_rdata,
	output logic                     list_we,
	output logic [AW-1:0]            list_waddr,
	output logic [AW-1:0]            list_wdata,
	output logic [AW-1:0]            list_raddr,
	input  wire logic [AW-1:0]       list_rdata
);
	localparam int DEPTH = 1 << AW;
	localparam int LW = AW + 1;
	localparam int HW = (CW > RW ? CW : RW) + 1;
	localparam int HBW = HW + 8;
	localparam int FSW = (HBW > 17 ? HBW : 17) + 1;

	gaps_pkg::state_t st_q, st_d;
	logic [LW-1:0] cnt_q, cnt_d, qlen_q, qlen_d, live_q, live_d, plen_q, plen_d;
	logic [AW-1:0] start_q, start_d, goal_q, goal_d, cur_q, cur_d, nb_q, nb_d;
	logic [AW-1:0] tile_q, tile_d, best_a_q, best_a_d, a_s2_q;
	logic [15:0] curg_q, curg_d, cost_q, cost_d;
	logic [2:0] k_q, k_d;
	logic diag_q, diag_d, found_q, found_d, have_q, have_d, v_s1_q, v_s2_q;
	logic [1:0] stat_q, stat_d;
	logic [HBW-1:0] h_q, h_d;
	logic [NW-1:0] best_w_q, best_w_d;

	// node word fields
	logic nr_blk, nr_opn, nr_cls, nr_pv;
	logic [15:0] nr_g;
	logic [16:0] nr_f, best_f;
	logic [AW-1:0] nr_par;
	assign nr_blk = node_rdata[NW-1];
	assign nr_opn = node_rdata[NW-2];
	assign nr_cls = node_rdata[NW-3];
	assign nr_g = node_rdata[NW-4 -: 16];
	assign nr_f = node_rdata[NW-20 -: 17];
	assign nr_pv = node_rdata[AW];
	assign nr_par = node_rdata[AW-1:0];
	assign best_f = best_w_q[NW-20 -: 17];

	// neighbor geometry
	logic [CW-1:0] cx, nx_n, nbx, gcx, dxa;
	logic [RW-1:0] cy, ny_n, nby, gcy, dya;
	logic signed [1:0] dx, dy;
	logic nb_out, k_last;
	assign cx = cur_q[CW-1:0];
	assign cy = cur_q[AW-1:CW];
	assign dx = gaps_pkg::nbr_dx(k_q);
	assign dy = gaps_pkg::nbr_dy(k_q);
	assign nb_out = (dx < 0 && cx == '0) || (dx > 0 && cx == CW'(GRID_COLS - 1)) ||
		(dy < 0 && cy == '0) || (dy > 0 && cy == RW'(GRID_ROWS - 1));
	assign nx_n = cx + CW'(dx);
	assign ny_n = cy + RW'(dy);
	assign k_last = (k_q == 3'd7);

	// heuristic of the neighbor held in nb_q
	logic [HW-1:0] hsum;
	assign nbx = nb_q[CW-1:0];
	assign nby = nb_q[AW-1:CW];
	assign gcx = goal_q[CW-1:0];
	assign gcy = goal_q[AW-1:CW];
	assign dxa = (gcx > nbx) ? gcx - nbx : nbx - gcx;
	assign dya = (gcy > nby) ? gcy - nby : nby - gcy;
	assign hsum = HW'(dxa) + HW'(dya);

	// step cost, saturating g and f
	logic [16:0] gsum;
	logic [15:0] g_new;
	logic [FSW-1:0] fsum;
	logic [16:0] f_new;
	assign gsum = 17'(curg_q) + 17'(diag_q ? dc : sc);
	assign g_new = (gsum > 17'(gaps_pkg::G_MAX)) ? gaps_pkg::G_MAX : gsum[15:0];
	assign fsum = FSW'(g_new) + FSW'(h_q);
	assign f_new = (fsum > FSW'(gaps_pkg::F_MAX)) ? gaps_pkg::F_MAX : fsum[16:0];

	// command decode
	logic [AW-1:0] cmd_addr, cmd_goal;
	logic cmd_ok, goal_ok;
	assign cmd_addr = {RW'(cmd.row), CW'(cmd.col)};
	assign cmd_goal = {RW'(cmd.goal_row), CW'(cmd.goal_col)};
	assign cmd_ok = (32'(cmd.col) < GRID_COLS) && (32'(cmd.row) < GRID_ROWS);
	assign goal_ok = (32'(cmd.goal_col) < GRID_COLS) && (32'(cmd.goal_row) < GRID_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gaps_pkg::S_INIT;
			cnt_q <= '0;
			found_q <= 1'b0;
			plen_q <= '0;
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			found_q <= found_d;
			plen_q <= plen_d;
			v_s1_q <= (st_q == gaps_pkg::S_SCAN) && (cnt_q < qlen_q);
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		qlen_q <= qlen_d;
		live_q <= live_d;
		start_q <= start_d;
		goal_q <= goal_d;
		cur_q <= cur_d;
		nb_q <= nb_d;
		tile_q <= tile_d;
		best_a_q <= best_a_d;
		a_s2_q <= list_rdata;
		curg_q <= curg_d;
		cost_q <= cost_d;
		k_q <= k_d;
		diag_q <= diag_d;
		have_q <= have_d;
		stat_q <= stat_d;
		h_q <= h_d;
		best_w_q <= best_w_d;
	end

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		qlen_d = qlen_q;
		live_d = live_q;
		plen_d = plen_q;
		start_d = start_q;
		goal_d = goal_q;
		cur_d = cur_q;
		nb_d = nb_q;
		tile_d = tile_q;
		best_a_d = best_a_q;
		curg_d = curg_q;
		cost_d = cost_q;
		k_d = k_q;
		diag_d = diag_q;
		found_d = found_q;
		have_d = have_q;
		stat_d = stat_q;
		h_d = h_q;
		best_w_d = best_w_q;
		node_we = 1'b0;
		node_waddr = cur_q;
		node_wdata = node_rdata;
		node_raddr = cur_q;
		list_we = 1'b0;
		list_waddr = qlen_q[AW-1:0];
		list_wdata = nb_q;
		list_raddr = cnt_q[AW-1:0];
		res_valid = 1'b0;
		hs_out.idle = 1'b0;
		hs_out.go = 1'b0;
		unique case (st_q)
			gaps_pkg::S_INIT: begin
				node_we = 1'b1;
				node_waddr = cnt_q[AW-1:0];
				node_wdata = '0;
				if (cnt_q == LW'(DEPTH - 1)) begin
					st_d = gaps_pkg::S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			gaps_pkg::S_IDLE: begin
				hs_out.idle = 1'b1;
				if (hs_in.go) begin
					tile_d = '0;
					stat_d = gaps_pkg::ST_OK;
					case (cmd.opcode) inside
						gaps_pkg::OP_BLOCK, gaps_pkg::OP_FREE: begin
							if (cmd_ok) begin
								node_we = 1'b1;
								node_waddr = cmd_addr;
								node_wdata = {cmd.opcode == gaps_pkg::OP_BLOCK,
									{(NW - 1){1'b0}}};
							end
							found_d = 1'b0;
							plen_d = '0;
							st_d = gaps_pkg::S_DONE;
						end
						gaps_pkg::OP_SEARCH: begin
							start_d = cmd_addr;
							goal_d = cmd_goal;
							qlen_d = '0;
							live_d = '0;
							plen_d = '0;
							cnt_d = '0;
							if (cmd_ok && goal_ok) begin
								st_d = gaps_pkg::S_CLR;
							end else begin
								found_d = 1'b0;
								stat_d = gaps_pkg::ST_NOPATH;
								st_d = gaps_pkg::S_DONE;
							end
						end
						default: begin
							list_raddr = AW'(cmd.entry_index);
							if (found_q && (32'(cmd.entry_index) < 32'(plen_q))) begin
								st_d = gaps_pkg::S_RWAIT;
							end else begin
								stat_d = gaps_pkg::ST_RANGE;
								st_d = gaps_pkg::S_DONE;
							end
						end
					endcase
				end
			end
			gaps_pkg::S_CLR: begin
				// stream through the node table keeping only the blocked bit
				node_raddr = cnt_q[AW-1:0];
				if (cnt_q != '0) begin
					node_we = 1'b1;
					node_waddr = AW'(cnt_q - 1'b1);
					node_wdata = {nr_blk, {(NW - 1){1'b0}}};
				end
				if (cnt_q == LW'(DEPTH)) begin
					st_d = gaps_pkg::S_SRD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			gaps_pkg::S_SRD: begin
				node_raddr = start_q;
				if (start_q == goal_q) begin
					found_d = 1'b1;
					cost_d = '0;
					st_d = gaps_pkg::S_DONE;
				end else begin
					st_d = gaps_pkg::S_SWR;
				end
			end
			gaps_pkg::S_SWR: begin
				node_we = 1'b1;
				node_waddr = start_q;
				node_wdata = {nr_blk, 1'b0, 1'b1, node_rdata[NW-4:0]};
				cur_d = start_q;
				curg_d = '0;
				k_d = '0;
				st_d = gaps_pkg::S_NA;
			end
			gaps_pkg::S_NA: begin
				if (nb_out) begin
					if (k_last) begin
						st_d = gaps_pkg::S_EXPEND;
					end else begin
						k_d = k_q + 3'd1;
					end
				end else begin
					nb_d = {ny_n, nx_n};
					diag_d = (dx != 0) && (dy != 0);
					node_raddr = {ny_n, cx};
					st_d = gaps_pkg::S_NB;
				end
			end
			gaps_pkg::S_NB: begin
				h_d = HBW'(hsum) * HBW'(sc);
				node_raddr = {cy, nbx};
				if (nr_blk) begin
					if (k_last) begin
						st_d = gaps_pkg::S_EXPEND;
					end else begin
						k_d = k_q + 3'd1;
						st_d = gaps_pkg::S_NA;
					end
				end else begin
					st_d = gaps_pkg::S_NC;
				end
			end
			gaps_pkg::S_NC: begin
				node_raddr = nb_q;
				if (nr_blk) begin
					if (k_last) begin
						st_d = gaps_pkg::S_EXPEND;
					end else begin
						k_d = k_q + 3'd1;
						st_d = gaps_pkg::S_NA;
					end
				end else begin
					st_d = gaps_pkg::S_NEV;
				end
			end
			gaps_pkg::S_NEV: begin
				node_waddr = nb_q;
				node_wdata = {nr_blk, 1'b1, 1'b0, g_new, f_new, 1'b1, cur_q};
				if (!(nb_q == start_q || nr_blk || nr_cls)) begin
					if (nr_opn) begin
						// re-parent only on a strictly cheaper route
						node_we = g_new < nr_g;
					end else begin
						node_we = 1'b1;
						list_we = 1'b1;
						qlen_d = qlen_q + 1'b1;
						live_d = live_q + 1'b1;
					end
				end
				if (k_last) begin
					st_d = gaps_pkg::S_EXPEND;
				end else begin
					k_d = k_q + 3'd1;
					st_d = gaps_pkg::S_NA;
				end
			end
			gaps_pkg::S_EXPEND: begin
				if (live_q == '0) begin
					found_d = 1'b0;
					plen_d = '0;
					stat_d = gaps_pkg::ST_NOPATH;
					st_d = gaps_pkg::S_DONE;
				end else begin
					cnt_d = '0;
					have_d = 1'b0;
					st_d = gaps_pkg::S_SCAN;
				end
			end
			gaps_pkg::S_SCAN: begin
				// list read, then node read, then first-minimum compare
				list_raddr = cnt_q[AW-1:0];
				if (cnt_q < qlen_q) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (v_s1_q) begin
					node_raddr = list_rdata;
				end
				if (v_s2_q && !nr_cls && (!have_q || nr_f < best_f)) begin
					have_d = 1'b1;
					best_a_d = a_s2_q;
					best_w_d = node_rdata;
				end
				if (cnt_q >= qlen_q && !v_s1_q && !v_s2_q) begin
					st_d = gaps_pkg::S_PICK;
				end
			end
			gaps_pkg::S_PICK: begin
				cur_d = best_a_q;
				curg_d = best_w_q[NW-4 -: 16];
				if (best_a_q == goal_q) begin
					cost_d = best_w_q[NW-4 -: 16];
					tile_d = goal_q;
					plen_d = '0;
					st_d = gaps_pkg::S_PRD;
				end else begin
					node_we = 1'b1;
					node_waddr = best_a_q;
					node_wdata = {best_w_q[NW-1], 1'b0, 1'b1, best_w_q[NW-4:0]};
					live_d = live_q - 1'b1;
					k_d = '0;
					st_d = gaps_pkg::S_NA;
				end
			end
			gaps_pkg::S_PRD: begin
				node_raddr = tile_q;
				st_d = gaps_pkg::S_PWR;
			end
			gaps_pkg::S_PWR: begin
				list_waddr = plen_q[AW-1:0];
				list_wdata = tile_q;
				if (nr_pv && plen_q < LW'(DEPTH)) begin
					list_we = 1'b1;
					plen_d = plen_q + 1'b1;
					tile_d = nr_par;
					st_d = gaps_pkg::S_PRD;
				end else begin
					found_d = 1'b1;
					stat_d = gaps_pkg::ST_OK;
					tile_d = '0;
					st_d = gaps_pkg::S_DONE;
				end
			end
			gaps_pkg::S_RWAIT: begin
				tile_d = list_rdata;
				st_d = gaps_pkg::S_DONE;
			end
			gaps_pkg::S_DONE: begin
				res_valid = 1'b1;
				st_d = gaps_pkg::S_IDLE;
			end
			default: begin
				st_d = gaps_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.status = stat_q;
		res.found = found_q;
		res.path_length = 13'(plen_q);
		res.tile_col = 6'(tile_q[CW-1:0]);
		res.tile_row = 6'(tile_q[AW-1:CW]);
		res.path_cost = (found_q && plen_q != '0) ? cost_q : 16'd0;
	end
endmodule
`default_nettype wire

FILE: hdl/grid_astar_path_search_unit.sv
// top level of the grid path search unit: config, memories, sequencer, output word
// block/free writes the tile map and answers; a path entry read first fetches the stored entry
// a search first sweeps the node table over every tile, then per expanded tile
// visits its neighbors and scans the open list for the lowest f,
// then walks the parent chain once per path tile; the single node table port sets the pace
// after reset a clearing pass of one tile per cycle (4096 tiles by default) frees the map
`default_nettype none
`include "grid_astar_path_search_unit_defines.svh"
module grid_astar_path_search_unit #(
	parameter int GRID_COLS = gaps_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gaps_pkg::GRID_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	gaps_req_if.sink        req,
	gaps_rsp_if.source      rsp,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);
	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int AW = CW + RW;
	localparam int NW = AW + 37;
	localparam int DEPTH = 1 << AW;

	// cost registers
	logic [7:0] sc_q, dc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= gaps_pkg::STRAIGHT_RST;
			dc_q <= gaps_pkg::DIAG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gaps_pkg::CFG_STRAIGHT: sc_q <= cfg_wdata;
				gaps_pkg::CFG_DIAG:     dc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: one command in flight, taken only when the output word is free or being taken
	gaps_pkg::ctl_hs_t hs_to_ctl, hs_from_ctl;
	logic rsp_valid_q;
	gaps_pkg::out_word_t rsp_word_q, res_word;
	logic res_valid;

	assign req.ready = hs_from_ctl.idle && (!rsp_valid_q || rsp.ready);
	assign hs_to_ctl.go = req.valid && req.ready;
	assign hs_to_ctl.idle = 1'b0;

	// node table: blocked, open, closed, g, f, parent valid, parent tile
	logic node_we;
	logic [AW-1:0] node_waddr, node_raddr;
	logic [NW-1:0] node_wdata, node_rdata;
	// list memory: open list during a search, stored path afterwards
	logic list_we;
	logic [AW-1:0] list_waddr, list_wdata, list_raddr, list_rdata;

	gaps_ram #(.W(NW), .DEPTH(DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	gaps_ram #(.W(AW), .DEPTH(DEPTH)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	gaps_ctrl #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.hs_in      (hs_to_ctl),
		.hs_out     (hs_from_ctl),
		.cmd        (req.data),
		.sc         (sc_q),
		.dc         (dc_q),
		.res_valid  (res_valid),
		.res        (res_word),
		.node_we    (node_we),
		.node_waddr (node_waddr),
		.node_wdata (node_wdata),
		.node_raddr (node_raddr),
		.node_rdata (node_rdata),
		.list_we    (list_we),
		.list_waddr (list_waddr),
		.list_wdata (list_wdata),
		.list_raddr (list_raddr),
		.list_rdata (list_rdata)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_word_q <= res_word;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_word_q;

	// a finished word never lands on one still waiting
	`GAPS_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, res_valid, !rsp_valid_q)
	// one command at a time
	`GAPS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`GAPS_ASSERT_IMPLY(a_status_code, clk, arst_n, rsp.valid, rsp.data.status == gaps_pkg::ST_OK || rsp.data.status == gaps_pkg::ST_NOPATH || rsp.data.status == gaps_pkg::ST_RANGE)
	// no stored path means no length and no cost
	`GAPS_ASSERT_IMPLY(a_empty_when_not_found, clk, arst_n, rsp.valid && !rsp.data.found, rsp.data.path_length == 13'd0 && rsp.data.path_cost == 16'd0)
endmodule
`default_nettype wire
